/* hdl/chmp_pkg.sv */
// shared constants and rounding helper for the cahn-hilliard material point
// no dependencies
package chmp_pkg;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOBILITY_COEFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERACTION_CHI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_KAPPA  = 2'd2;

    // clamp window in q8.24: tol is 1e-5 rounded
    localparam logic signed [31:0] TOL_Q24   = 32'sd168;
    localparam logic signed [31:0] C_MAX_Q24 = 32'sd16777048;
    localparam logic signed [31:0] RESET_D   = 32'sd16777216;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    // log: one squaring per stage, plus normalize and scale stages
    localparam int LOG_STEPS = 24;
    localparam int LOG_LAT   = LOG_STEPS + 2;

    // reciprocal: quotient of 2^48/x stays below 2^41 since x >= tol
    localparam int QBITS    = 41;
    localparam int REC_LAT  = QBITS;
    // top bits of the dividend above the quotient window, always below x
    localparam logic [23:0] REC_SEED = 24'd128;

    // q.48 product to q.24, round half up
    function automatic logic signed [OUT_W-1:0] round_q24(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd8388608) >>> 24;
        return t[OUT_W-1:0];
    endfunction

endpackage

/* hdl/cahn_hilliard_material_point_top.sv */
// top level of the cahn-hilliard flory-huggins material point pipeline
// depends on chmp_pkg, chmp_delay, chmp_log, chmp_recip
//
// usage:
//   a request is taken at each rising edge with start high; busy is tied low,
//   so a new concentration sample can enter in every cycle
//   the five q24.24 results appear together in the output registers,
//   marked by done for exactly one cycle; the receiver cannot stall, and the
//   pipeline never holds off, so one request in gives one result out
//   latency is set by the reciprocal divider, one quotient bit per stage
//   (41 stages); the log branch (26 stages: normalize, 24 squarings, scale)
//   is padded to match
//   throughput: one sample per cycle
//   configuration: cfg_we with cfg_index 0 = mobility D, 1 = chi, 2 = kappa;
//   index 3 is ignored; write only while no request is in flight
//   reset: D returns to 1.0, chi and kappa to 0, and all pipeline valid
//   bits clear, so no stray done pulse appears after reset
module cahn_hilliard_material_point_top
    import chmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [31:0]      concentration,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    output logic                    done,
    output logic signed [OUT_W-1:0] mobility,
    output logic signed [OUT_W-1:0] mobility_slope,
    output logic signed [OUT_W-1:0] free_energy,
    output logic signed [OUT_W-1:0] chem_potential,
    output logic signed [OUT_W-1:0] potential_slope
);

    // depths that align each branch to the stage where all have their value
    localparam int LOG_SUM_DLY = REC_LAT - LOG_LAT - 4;
    localparam int CHI_DLY     = REC_LAT - 3;

    assign busy = 1'b0;

    // configuration registers
    logic signed [31:0] mobility_coeff_reg;
    logic signed [31:0] interaction_chi_reg;
    logic signed [31:0] gradient_kappa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mobility_coeff_reg  <= RESET_D;
            interaction_chi_reg <= '0;
            gradient_kappa_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MOBILITY_COEFF:  mobility_coeff_reg  <= cfg_wdata;
                REG_INTERACTION_CHI: interaction_chi_reg <= cfg_wdata;
                REG_GRADIENT_KAPPA:  gradient_kappa_reg  <= cfg_wdata;
                default:             gradient_kappa_reg  <= gradient_kappa_reg;
            endcase
        end
    end

    // stage 1: clamp to [tol, 1-tol], form u = 1-c
    logic signed [31:0] c_clamp;
    logic [23:0]        c_reg;
    logic [23:0]        u_reg;
    logic               v1_reg;

    always_comb
    begin
        c_clamp = concentration;
        if (concentration < TOL_Q24)
        begin
            c_clamp = TOL_Q24;
        end
        else if (concentration > C_MAX_Q24)
        begin
            c_clamp = C_MAX_Q24;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_clamp[23:0];
        u_reg <= 24'(25'd16777216 - {1'b0, c_clamp[23:0]});
    end

    // stage 2: c*u rounded and 1-2c
    logic [23:0]        cu_reg;
    logic signed [25:0] om2c_reg;
    logic [47:0]        cu_full;

    assign cu_full = ({24'b0, c_reg} * {24'b0, u_reg}) + 48'd8388608;

    always_ff @(posedge clk)
    begin
        cu_reg   <= cu_full[47:24];
        om2c_reg <= 26'sd16777216 - $signed({1'b0, c_reg, 1'b0});
    end

    // stage 3: coefficient products
    logic signed [56:0] p_dcu_reg;
    logic signed [57:0] p_dom_reg;
    logic signed [56:0] p_chicu_reg;
    logic signed [57:0] p_chiom_reg;

    always_ff @(posedge clk)
    begin
        p_dcu_reg   <= mobility_coeff_reg * $signed({1'b0, cu_reg});
        p_dom_reg   <= mobility_coeff_reg * om2c_reg;
        p_chicu_reg <= interaction_chi_reg * $signed({1'b0, cu_reg});
        p_chiom_reg <= interaction_chi_reg * om2c_reg;
    end

    // stage 4: round to q.24
    logic signed [OUT_W-1:0] mob_reg;
    logic signed [OUT_W-1:0] mslope_reg;
    logic signed [OUT_W-1:0] fe_chi_reg;
    logic signed [OUT_W-1:0] cp_chi_reg;

    always_ff @(posedge clk)
    begin
        mob_reg    <= round_q24(64'(p_dcu_reg));
        mslope_reg <= round_q24(64'(p_dom_reg));
        fe_chi_reg <= round_q24(64'(p_chicu_reg));
        cp_chi_reg <= round_q24(64'(p_chiom_reg));
    end

    logic [4*OUT_W-1:0] chi_dly;

    chmp_delay #(
        .WIDTH(4*OUT_W),
        .DEPTH(CHI_DLY)
    ) u_chi_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .din  ({mob_reg, mslope_reg, fe_chi_reg, cp_chi_reg}),
        .dout (chi_dly)
    );

    // log branch
    logic signed [31:0] lnc;
    logic signed [31:0] lnu;

    chmp_log u_log_c (
        .clk(clk),
        .x  (c_reg),
        .ln (lnc)
    );

    chmp_log u_log_u (
        .clk(clk),
        .x  (u_reg),
        .ln (lnu)
    );

    logic [47:0] cu_dly;

    chmp_delay #(
        .WIDTH(48),
        .DEPTH(LOG_LAT + 1)
    ) u_cu_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .din  ({c_reg, u_reg}),
        .dout (cu_dly)
    );

    logic signed [31:0] lnc_reg;
    logic signed [31:0] lnu_reg;
    logic signed [56:0] p_clnc_reg;
    logic signed [56:0] p_ulnu_reg;
    logic signed [31:0] lnc2_reg;
    logic signed [31:0] lnu2_reg;
    logic signed [31:0] lnc3_reg;
    logic signed [31:0] lnu3_reg;
    logic signed [OUT_W-1:0] t_c_reg;
    logic signed [OUT_W-1:0] t_u_reg;
    logic signed [OUT_W-1:0] fe_log_reg;
    logic signed [OUT_W-1:0] cp_log_reg;

    always_ff @(posedge clk)
    begin
        lnc_reg    <= lnc;
        lnu_reg    <= lnu;
        p_clnc_reg <= $signed({1'b0, cu_dly[47:24]}) * lnc_reg;
        p_ulnu_reg <= $signed({1'b0, cu_dly[23:0]}) * lnu_reg;
        lnc2_reg   <= lnc_reg;
        lnu2_reg   <= lnu_reg;
        t_c_reg    <= round_q24(64'(p_clnc_reg));
        t_u_reg    <= round_q24(64'(p_ulnu_reg));
        lnc3_reg   <= lnc2_reg;
        lnu3_reg   <= lnu2_reg;
        fe_log_reg <= t_c_reg + t_u_reg;
        cp_log_reg <= OUT_W'(lnc3_reg) - OUT_W'(lnu3_reg);
    end

    logic [2*OUT_W-1:0] log_dly;

    chmp_delay #(
        .WIDTH(2*OUT_W),
        .DEPTH(LOG_SUM_DLY)
    ) u_log_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .din  ({fe_log_reg, cp_log_reg}),
        .dout (log_dly)
    );

    // reciprocal branch
    logic [QBITS-1:0] rc;
    logic [QBITS-1:0] ru;

    chmp_recip u_recip_c (
        .clk(clk),
        .x  (c_reg),
        .q  (rc)
    );

    chmp_recip u_recip_u (
        .clk(clk),
        .x  (u_reg),
        .q  (ru)
    );

    // valid alongside the data
    logic v_dly;

    chmp_delay #(
        .WIDTH(1),
        .DEPTH(REC_LAT)
    ) u_v_dly (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (v1_reg),
        .dout (v_dly)
    );

    // output stage
    logic signed [OUT_W-1:0] two_chi;
    assign two_chi = {{(OUT_W-33){interaction_chi_reg[31]}}, interaction_chi_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= v_dly;
        end
    end

    always_ff @(posedge clk)
    begin
        mobility        <= chi_dly[4*OUT_W-1:3*OUT_W];
        mobility_slope  <= chi_dly[3*OUT_W-1:2*OUT_W];
        free_energy     <= log_dly[2*OUT_W-1:OUT_W] + chi_dly[2*OUT_W-1:OUT_W];
        chem_potential  <= log_dly[OUT_W-1:0] + chi_dly[OUT_W-1:0];
        potential_slope <= $signed(OUT_W'(rc)) + $signed(OUT_W'(ru)) - two_chi;
    end

endmodule

/* hdl/chmp_delay.sv */
// fixed-length shift line aligning data between pipeline branches
// depends on nothing
module chmp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* hdl/chmp_log.sv */
// pipelined natural log of a positive q.24 value, one squaring per stage
// depends on chmp_pkg
module chmp_log
    import chmp_pkg::*;
(
    input  logic               clk,
    input  logic [23:0]        x,
    output logic signed [31:0] ln
);

    logic [30:0] m_reg    [0:LOG_STEPS];
    logic [23:0] frac_reg [0:LOG_STEPS];
    logic [4:0]  e_reg    [0:LOG_STEPS];
    logic signed [62:0] prod_reg;

    logic [4:0]  lead;
    logic [30:0] m_norm;

    // leading one position
    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (x[i])
            begin
                lead = 5'(i);
            end
        end
        m_norm = 31'({7'b0, x} << (5'd30 - lead));
    end

    always_ff @(posedge clk)
    begin
        m_reg[0]    <= m_norm;
        frac_reg[0] <= '0;
        e_reg[0]    <= 5'd24 - lead;
    end

    for (genvar s = 1; s <= LOG_STEPS; s++)
    begin : g_sq
        logic [61:0] sq;
        logic [31:0] sqh;
        assign sq  = {31'b0, m_reg[s-1]} * {31'b0, m_reg[s-1]};
        assign sqh = sq[61:30];

        always_ff @(posedge clk)
        begin
            m_reg[s]    <= sqh[31] ? sqh[31:1] : sqh[30:0];
            frac_reg[s] <= {frac_reg[s-1][22:0], sqh[31]};
            e_reg[s]    <= e_reg[s-1];
        end
    end

    logic signed [29:0] l2;
    assign l2 = $signed({6'b0, frac_reg[LOG_STEPS]})
              - $signed({1'b0, e_reg[LOG_STEPS], 24'b0});

    always_ff @(posedge clk)
    begin
        prod_reg <= l2 * $signed({1'b0, LN2_Q32});
    end

    logic signed [62:0] ln_wide;
    assign ln_wide = (prod_reg + 63'sd2147483648) >>> 32;
    assign ln      = ln_wide[31:0];

endmodule

/* hdl/chmp_recip.sv */
// pipelined rounded reciprocal (2^48 + x/2) / x, one quotient bit per stage
// depends on chmp_pkg
module chmp_recip
    import chmp_pkg::*;
(
    input  logic             clk,
    input  logic [23:0]      x,
    output logic [QBITS-1:0] q
);

    logic [23:0]      r_reg [0:QBITS-1];
    logic [23:0]      x_reg [0:QBITS-1];
    logic [QBITS-1:0] q_reg [0:QBITS-1];

    for (genvar j = 0; j < QBITS; j++)
    begin : g_div
        localparam int K = QBITS - 1 - j;
        logic [23:0]      r_prev;
        logic [23:0]      x_prev;
        logic [QBITS-1:0] q_prev;
        logic [QBITS-1:0] n_low;
        logic [24:0]      trial;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign r_prev = REC_SEED;
            assign x_prev = x;
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign r_prev = r_reg[j-1];
            assign x_prev = x_reg[j-1];
            assign q_prev = q_reg[j-1];
        end

        // low dividend bits are x/2
        assign n_low = QBITS'({1'b0, x_prev[23:1]});
        assign trial = {r_prev, n_low[K]};
        assign ge    = trial >= {1'b0, x_prev};

        always_ff @(posedge clk)
        begin
            r_reg[j] <= ge ? 24'(trial - {1'b0, x_prev}) : trial[23:0];
            x_reg[j] <= x_prev;
            q_reg[j] <= {q_prev[QBITS-2:0], ge};
        end
    end

    assign q = q_reg[QBITS-1];

endmodule
